[rtl/core/tsmb_pkg.sv]
// Shared types and constants for the timestamp matched buffer.
// No dependencies; imported by the store and the top level.
`default_nettype none

package tsmb_pkg;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_PURGE = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;

  // register reset values
  localparam logic [5:0]  MAX_SIZE_RST  = 6'd25;
  localparam logic [63:0] TOLERANCE_RST = 64'd0;

  // one stored entry
  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] payload;
  } tsmb_entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_FINISH
  } tsmb_state_t;

endpackage

`default_nettype wire

[rtl/core/tsmb_store.sv]
// Entry memory of the timestamp matched buffer: one write port, one
// registered read port. Depends on tsmb_pkg for the entry type.
`default_nettype none

module tsmb_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire [AW-1:0]               wr_addr,
  input  wire tsmb_pkg::tsmb_entry_t wr_data,
  input  wire [AW-1:0]               rd_addr,
  output tsmb_pkg::tsmb_entry_t      rd_data
);
  import tsmb_pkg::*;

  tsmb_entry_t mem [DEPTH];
  tsmb_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/tsmb_range_cmp.sv]
// Shared window compare unit: tests a stored stamp against [lo, hi].
// Used for both purge (lo = 0, hi = limit) and find. No dependencies.
`default_nettype none

module tsmb_range_cmp (
  input  wire [63:0] stamp,
  input  wire [63:0] lo,
  input  wire [63:0] hi,
  output logic       in_range
);

  // both bounds inclusive
  always_comb begin
    in_range = (stamp >= lo) && (stamp <= hi);
  end

endmodule

`default_nettype wire

[rtl/core/timestamp_matched_buffer.sv]
// Timestamp matched buffer: circular store walked by a sequencer driving one
// shared window compare unit. Depends on tsmb_pkg, tsmb_store, tsmb_range_cmp.
// Add goes through ST_ADD_RD and ST_ADD_WR to ST_FINISH; purge and find scan
// the n stored entries in ST_SCAN (one entry a cycle through the store read port).
// One word at a time: the next word is taken the cycle after the result loads;
// find stops at its first match, and a held result word stalls the sequencer
// in its last state.
// Reset (synchronous, rst_n low): list empty, max_size 25, tolerance 0.
`default_nettype none

module timestamp_matched_buffer #(
  parameter int DEPTH = 32
) (
  input  wire          clk,
  input  wire          rst_n,
  // input words
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [95:0]  in_tdata,   // [63:0] timestamp, [95:64] payload
  input  wire  [1:0]   in_tuser,   // [1:0] req_type
  // result words
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [103:0] out_tdata,  // [31:0] result_payload, [95:32] result_timestamp,
                                   // [101:96] removed_count, [103:102] zero
  output logic         out_tuser,  // [0] hit
  // configuration
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [3:0]   cfg_paddr,
  input  wire  [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import tsmb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (CW > 6) ? CW : 6;

  // circular address wrap; both operands stay below DEPTH or at it
  function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

  tsmb_state_t state_r, state_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rv_r, rv_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [63:0]   ts_r, ts_nxt;
  logic [31:0]   pl_r, pl_nxt;
  logic [63:0]   lo_r, lo_nxt;
  logic [63:0]   hi_r, hi_nxt;

  logic          res_hit_r, res_hit_nxt;
  logic [31:0]   res_pl_r, res_pl_nxt;
  logic [63:0]   res_ts_r, res_ts_nxt;
  logic [5:0]    res_cnt_r, res_cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [31:0]   out_pl_r, out_pl_nxt;
  logic [63:0]   out_ts_r, out_ts_nxt;
  logic [5:0]    out_cnt_r, out_cnt_nxt;

  logic [5:0]    max_size_r;
  logic [63:0]   tol_r;

  // store and compare unit hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  tsmb_entry_t   mem_wdata;
  logic [AW-1:0] mem_raddr;
  tsmb_entry_t   mem_rdata;
  logic          match;

  tsmb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  tsmb_range_cmp u_cmp (
    .stamp    (mem_rdata.stamp),
    .lo       (lo_r),
    .hi       (hi_r),
    .in_range (match)
  );

  // input word fields
  logic        in_fire;
  logic [63:0] in_ts;
  logic [31:0] in_pl;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_ts     = in_tdata[63:0];
  assign in_pl     = in_tdata[95:64];

  // saturated find window
  logic [64:0] win_sum, win_dif;
  logic [63:0] win_lo, win_hi;
  always_comb begin
    win_sum = {1'b0, in_ts} + {1'b0, tol_r};
    win_dif = {1'b0, in_ts} - {1'b0, tol_r};
    win_hi  = win_sum[64] ? {64{1'b1}} : win_sum[63:0];
    win_lo  = win_dif[64] ? 64'd0 : win_dif[63:0];
  end

  // effective max_size, clamped to [1, DEPTH]; eviction test for add
  logic [EW-1:0] max_ext, eff_max;
  logic          evict;
  always_comb begin
    max_ext = EW'(max_size_r);
    if (max_ext == '0) begin
      eff_max = EW'(1);
    end else if (max_ext > EW'(DEPTH)) begin
      eff_max = EW'(DEPTH);
    end else begin
      eff_max = max_ext;
    end
    evict = (occ_r != '0) && (EW'(occ_r) >= eff_max);
  end

  logic scan_end;
  assign scan_end = !rv_r && (rd_idx_r == occ_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            REQ_ADD:   state_nxt = ST_ADD_RD;
            REQ_PURGE: state_nxt = ST_SCAN;
            REQ_FIND:  state_nxt = ST_SCAN;
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: state_nxt = ST_FINISH;
      ST_SCAN: begin
        if (rv_r && (req_r == REQ_FIND) && match) begin
          state_nxt = ST_FINISH;
        end else if (scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and store controls
  logic [CW-1:0] occ_after;
  always_comb begin
    head_nxt    = head_r;
    occ_nxt     = occ_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    cnt_nxt     = cnt_r;
    rv_nxt      = rv_r;
    req_nxt     = req_r;
    ts_nxt      = ts_r;
    pl_nxt      = pl_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    res_hit_nxt = res_hit_r;
    res_pl_nxt  = res_pl_r;
    res_ts_nxt  = res_ts_r;
    res_cnt_nxt = res_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_hit_nxt = out_hit_r;
    out_pl_nxt  = out_pl_r;
    out_ts_nxt  = out_ts_r;
    out_cnt_nxt = out_cnt_r;
    occ_after   = occ_r;
    mem_we      = 1'b0;
    mem_waddr   = wrap_addr(SW'(head_r) + SW'(occ_r));
    mem_wdata   = mem_rdata;
    mem_raddr   = wrap_addr(SW'(head_r) + SW'(rd_idx_r));

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt     = in_tuser;
          ts_nxt      = in_ts;
          pl_nxt      = in_pl;
          rd_idx_nxt  = '0;
          wr_idx_nxt  = '0;
          cnt_nxt     = '0;
          rv_nxt      = 1'b0;
          res_hit_nxt = 1'b0;
          res_pl_nxt  = '0;
          res_ts_nxt  = '0;
          res_cnt_nxt = '0;
          // purge limit is the window [0, timestamp]
          if (in_tuser == REQ_PURGE) begin
            lo_nxt = '0;
            hi_nxt = in_ts;
          end else begin
            lo_nxt = win_lo;
            hi_nxt = win_hi;
          end
        end
      end
      ST_ADD_RD: begin
        // read at head is in flight (rd_idx is zero)
      end
      ST_ADD_WR: begin
        // drop the oldest, then append at the tail; tail address is
        // head + occupancy either way
        if (evict) begin
          res_hit_nxt = 1'b1;
          res_pl_nxt  = mem_rdata.payload;
          res_ts_nxt  = mem_rdata.stamp;
          head_nxt    = wrap_addr(SW'(head_r) + SW'(1));
          occ_after   = occ_r - 1'b1;
        end
        if (occ_after < CW'(DEPTH)) begin
          mem_we          = 1'b1;
          mem_wdata.stamp = ts_r;
          mem_wdata.payload = pl_r;
          occ_nxt         = occ_after + 1'b1;
        end else begin
          occ_nxt = occ_after;
        end
      end
      ST_SCAN: begin
        // issue reads one entry a cycle
        if (rd_idx_r != occ_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          rv_nxt     = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        // compare the entry read last cycle
        if (rv_r) begin
          if (req_r == REQ_FIND) begin
            if (match) begin
              res_hit_nxt = 1'b1;
              res_pl_nxt  = mem_rdata.payload;
              res_ts_nxt  = mem_rdata.stamp;
            end
          end else if (match) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            // keep: compact toward head, never past the read point
            mem_we     = 1'b1;
            mem_waddr  = wrap_addr(SW'(head_r) + SW'(wr_idx_r));
            mem_wdata  = mem_rdata;
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
        end
        if (scan_end && (req_r == REQ_PURGE)) begin
          occ_nxt     = wr_idx_r;
          res_cnt_nxt = 6'(cnt_r);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_pl_nxt    = res_pl_r;
          out_ts_nxt    = res_ts_r;
          out_cnt_nxt   = res_cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ts_r      <= ts_nxt;
    pl_r      <= pl_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    res_hit_r <= res_hit_nxt;
    res_pl_r  <= res_pl_nxt;
    res_ts_r  <= res_ts_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_hit_r <= out_hit_nxt;
    out_pl_r  <= out_pl_nxt;
    out_ts_r  <= out_ts_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // configuration registers: max_size at 0, tolerance at 8
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
      tol_r      <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[3]) begin
        tol_r <= cfg_pwdata;
      end else begin
        max_size_r <= cfg_pwdata[5:0];
      end
    end
  end

  assign cfg_prdata = cfg_paddr[3] ? tol_r : {58'd0, max_size_r};

  // result word
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_ts_r, out_pl_r};

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for timestamp_matched_buffer: streams add, purge and find
// words while a mirror of the entry list predicts every result word.
// Depends on tsmb_pkg and the timestamp_matched_buffer RTL.
`timescale 1ns / 100ps

module testbench;
  import tsmb_pkg::*;

  localparam int DEPTH = 32;
  // request kind the block leaves unused
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // register byte addresses (64-bit register present, so 8 bytes apart)
  localparam logic [3:0] ADDR_MAX_SIZE  = 4'd0;
  localparam logic [3:0] ADDR_TOLERANCE = 4'd8;
  localparam logic [63:0] STAMP_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        hit;
    logic [31:0] payload;
    logic [63:0] stamp;
    logic [5:0]  removed;
  } lookup_result_t;

  // Mirror of the entry list; predicts one result word per request word
  class entry_list_mirror;
    logic [63:0] stamps [DEPTH];
    logic [31:0] payloads [DEPTH];
    int unsigned fill;
    logic [5:0] max_size;
    logic [63:0] tolerance;
    lookup_result_t pending_results[$];
    int unsigned mismatch_count;

    function new();
      fill = 0;
      max_size = MAX_SIZE_RST;
      tolerance = TOLERANCE_RST;
      mismatch_count = 0;
    endfunction

    // remove one entry, older entries keep their order
    function void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < fill; i++) begin
        stamps[i] = stamps[i + 1];
        payloads[i] = payloads[i + 1];
      end
      fill--;
    endfunction

    function void note_request(logic [1:0] kind, logic [63:0] ts, logic [31:0] pl);
      lookup_result_t r;
      int unsigned limit;
      int unsigned i;
      logic [63:0] lo;
      logic [63:0] hi;
      r = '0;
      case (kind)
        REQ_ADD: begin
          // zero acts as one, anything above the depth as the depth
          if (max_size == 0) limit = 1;
          else if (max_size > DEPTH) limit = DEPTH;
          else limit = max_size;
          // only the oldest entry goes, even if the list is still over the limit
          if (fill + 1 > limit && fill > 0) begin
            r.hit = 1'b1;
            r.payload = payloads[0];
            r.stamp = stamps[0];
            drop_entry(0);
          end
          if (fill < DEPTH) begin
            stamps[fill] = ts;
            payloads[fill] = pl;
            fill++;
          end
        end
        REQ_PURGE: begin
          i = 0;
          while (i < fill) begin
            if (stamps[i] <= ts) begin
              drop_entry(i);
              r.removed = r.removed + 6'd1;
            end else begin
              i++;
            end
          end
        end
        REQ_FIND: begin
          // window saturates at both ends of the stamp range
          lo = (ts >= tolerance) ? ts - tolerance : 64'd0;
          hi = (ts > ~tolerance) ? STAMP_MAX : ts + tolerance;
          for (i = 0; i < fill && !r.hit; i++) begin
            if (stamps[i] >= lo && stamps[i] <= hi) begin
              r.hit = 1'b1;
              r.payload = payloads[i];
              r.stamp = stamps[i];
            end
          end
        end
        default: ;
      endcase
      pending_results = {pending_results, r};
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic [103:0] data, logic flag);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        report("unrequested word", 64'd0, data[63:0]);
        return;
      end
      want = pending_results.pop_front();
      if (flag !== want.hit) report("hit", 64'(want.hit), 64'(flag));
      if (data[31:0] !== want.payload)
        report("result_payload", 64'(want.payload), 64'(data[31:0]));
      if (data[95:32] !== want.stamp) report("result_timestamp", want.stamp, data[95:32]);
      if (data[101:96] !== want.removed)
        report("removed_count", 64'(want.removed), 64'(data[101:96]));
      if (data[103:102] !== 2'b00) report("pad bits", 64'd0, 64'(data[103:102]));
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [95:0]   in_tdata;   // [63:0] timestamp, [95:64] payload
  logic [1:0]    in_tuser;   // [1:0] req_type
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [103:0]  out_tdata;  // [31:0] result_payload, [95:32] result_timestamp,
                             // [101:96] removed_count, [103:102] zero
  logic          out_tuser;  // [0] hit
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [3:0]    cfg_paddr;
  logic [63:0]   cfg_pwdata;
  logic [63:0]   cfg_prdata;
  logic          cfg_pready;

  entry_list_mirror tracker;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [63:0] stamp_clock;

  timestamp_matched_buffer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: check accepted words, then pick next tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one request word; optional hold until every result is back
  task automatic send_request(input logic [1:0] kind, input logic [63:0] ts,
                              input logic [31:0] pl, input bit drain_first);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (drain_first) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_first && tracker.pending_results.size() != 0) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {pl, ts};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(kind, ts, pl);
  endtask

  // stop sending and let the block go quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write a register while idle, then read it back
  task automatic write_register(input logic [3:0] addr, input logic [63:0] value);
    logic [63:0] mask;
    wait_idle();
    mask = (addr == ADDR_MAX_SIZE) ? 64'h3F : STAMP_MAX;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if ((cfg_prdata & mask) !== (value & mask))
      tracker.report("register readback", value & mask, cfg_prdata & mask);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_MAX_SIZE) tracker.max_size = value[5:0];
    else tracker.tolerance = value;
  endtask

  // random word: mostly stamps that advance in time, finds aimed at stored entries
  task automatic make_request(output logic [1:0] kind, output logic [63:0] ts,
                              output logic [31:0] pl);
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    pl = $urandom;
    stamp_clock = stamp_clock + $urandom_range(0, 40);
    if (roll < 50) begin
      kind = REQ_ADD;
      ts = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : stamp_clock;
    end else if (roll < 62) begin
      kind = REQ_PURGE;
      ts = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                         : stamp_clock - $urandom_range(0, 600);
    end else if (roll < 95) begin
      kind = REQ_FIND;
      if (tracker.fill > 0 && $urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, tracker.fill - 1);
        ts = tracker.stamps[pick] + $urandom_range(0, 40) - 64'd20;
      end else begin
        ts = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom}
                                         : stamp_clock - $urandom_range(0, 2000);
      end
    end else begin
      kind = REQ_UNUSED;
      ts = {$urandom, $urandom};
    end
  endtask

  // stimulus
  initial begin
    logic [1:0]  kind;
    logic [63:0] ts;
    logic [31:0] pl;
    logic [63:0] tol;
    logic [5:0]  limit;
    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 27;
    recv_stall_pct = 52;
    stamp_clock = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, unused kind, reset register values
    send_request(REQ_FIND, 64'd0, 32'd0, 0);
    send_request(REQ_PURGE, STAMP_MAX, 32'd0, 0);
    send_request(REQ_UNUSED, 64'd0, 32'd0, 0);
    send_request(REQ_ADD, 64'd0, 32'd0, 0);
    send_request(REQ_ADD, STAMP_MAX, 32'hFFFF_FFFF, 0);
    send_request(REQ_ADD, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 0);
    send_request(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 0);
    send_request(REQ_FIND, 64'd0, 32'd0, 0);
    send_request(REQ_FIND, STAMP_MAX, 32'd0, 0);
    send_request(REQ_FIND, 64'h5555_5555_5555_5556, 32'd0, 0);
    send_request(REQ_UNUSED, STAMP_MAX, 32'hFFFF_FFFF, 0);
    send_request(REQ_PURGE, 64'd0, 32'd0, 0);
    send_request(REQ_ADD, 64'd3, 32'd1, 0);
    // window clamped at zero and at the top of the range
    write_register(ADDR_TOLERANCE, 64'd10);
    send_request(REQ_FIND, 64'd5, 32'd0, 0);
    send_request(REQ_FIND, STAMP_MAX - 64'd3, 32'd0, 0);
    write_register(ADDR_TOLERANCE, STAMP_MAX);
    send_request(REQ_FIND, 64'h1234, 32'd0, 0);
    // limit lowered below occupancy: one eviction per add
    write_register(ADDR_MAX_SIZE, 64'd1);
    send_request(REQ_ADD, 64'd100, 32'h0000_0100, 0);
    send_request(REQ_ADD, 64'd101, 32'h0000_0101, 0);
    send_request(REQ_PURGE, STAMP_MAX, 32'd0, 0);
    send_request(REQ_ADD, 64'd200, 32'h0000_0200, 0);
    send_request(REQ_ADD, 64'd201, 32'h0000_0201, 0);
    // zero limit acts as one
    write_register(ADDR_MAX_SIZE, 64'd0);
    send_request(REQ_ADD, 64'd202, 32'h0000_0202, 0);
    send_request(REQ_ADD, 64'd203, 32'h0000_0203, 0);

    // random phases, each with its own register setting; pairs of phases share an idle pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin limit = 6'd32; tol = $urandom_range(0, 20); end
        1: begin limit = 6'd3;  tol = 64'd0; end
        2: begin limit = 6'd63; tol = {$urandom, $urandom}; end
        3: begin limit = 6'd0;  tol = STAMP_MAX; end
        4: begin limit = 6'd17; tol = $urandom_range(0, 100); end
        default: begin limit = 6'd25; tol = 64'd5; end
      endcase
      write_register(ADDR_MAX_SIZE, {58'd0, limit});
      write_register(ADDR_TOLERANCE, tol);
      if (ph < 2) begin
        send_idle_pct = 27;
        recv_stall_pct = 52;
      end else if (ph < 4) begin
        send_idle_pct = 52;
        recv_stall_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // stamps near zero, near wrap-around, or anywhere
      if (ph == 2) stamp_clock = STAMP_MAX - 64'd4000;
      else if (ph == 4) stamp_clock = 64'd0;
      else stamp_clock = {$urandom, $urandom};
      for (int n = 0; n < 300; n++) begin
        make_request(kind, ts, pl);
        send_request(kind, ts, pl, (ph == 1 && n == 150));
      end
    end

    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
